// ===== rtl/core/sdspi_pkg.sv =====
// Package for the SD card SPI-mode sequencer.
// Holds the shared constants, the command step and result types and the frame byte function.
// It has no dependencies.
`default_nettype none

package sdspi_pkg;

    localparam int BLOCK_BYTES  = 512;
    localparam int INIT_RETRIES = 1024;
    localparam int WAKE_BYTES   = 10;

    localparam int BC_MAX  = (BLOCK_BYTES > WAKE_BYTES + 1) ? BLOCK_BYTES : WAKE_BYTES + 1;
    localparam int BC_W    = (BC_MAX > 8) ? $clog2(BC_MAX) : 3;
    localparam int RETRY_W = $clog2(INIT_RETRIES + 1);
    localparam int LIMIT_W = 16;

    localparam logic [7:0] FILL_BYTE   = 8'hFF;
    localparam logic [7:0] START_TOKEN = 8'hFE;
    localparam logic [7:0] ERR_MASK    = 8'hE0;
    localparam logic [7:0] CMD0_BUSY   = 8'h3F;
    localparam logic [6:0] R1_IDLE     = 7'h01;
    localparam logic [6:0] R1_READY    = 7'h00;

    localparam logic [LIMIT_W-1:0] REPLY_LIMIT_RST = 16'd8;
    localparam logic [LIMIT_W-1:0] TOKEN_LIMIT_RST = 16'd4096;

    typedef enum logic [1:0] {
        ACT_INIT = 2'd0,
        ACT_READ = 2'd1,
        ACT_XFER = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [0:0] {
        CFG_REPLY_LIMIT = 1'b0,
        CFG_TOKEN_LIMIT = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        S_CMD0A,
        S_CMD0B,
        S_CMD8,
        S_CMD55,
        S_ACMD41,
        S_CMD58,
        S_CMD17
    } t_cmd_step;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       card_select;
        logic [7:0] data_byte;
        logic       data_valid;
        logic       done_res;
        logic [7:0] status;
        logic       timed_out;
    } t_result;

    // Byte k of the six-byte command frame for a given command step.
    function automatic logic [7:0] frame_byte(t_cmd_step step, logic [2:0] k,
                                              logic [31:0] addr);
        logic [5:0]  cmd;
        logic [31:0] arg;
        logic [6:0]  crc;
        logic [7:0]  b;
        cmd = 6'd17;
        arg = addr;
        crc = 7'h00;
        case (step)
            S_CMD0A, S_CMD0B: begin
                cmd = 6'd0;
                arg = 32'h0;
                crc = 7'h4A;
            end
            S_CMD8: begin
                cmd = 6'd8;
                arg = 32'h0000_01AA;
                crc = 7'h43;
            end
            S_CMD55: begin
                cmd = 6'd55;
                arg = 32'h0;
            end
            S_ACMD41: begin
                cmd = 6'd41;
                arg = 32'h4000_0000;
            end
            S_CMD58: begin
                cmd = 6'd58;
                arg = 32'h0;
            end
            default: begin
                cmd = 6'd17;
                arg = addr;
            end
        endcase
        case (k)
            3'd0:    b = {2'b01, cmd};
            3'd1:    b = arg[31:24];
            3'd2:    b = arg[23:16];
            3'd3:    b = arg[15:8];
            3'd4:    b = arg[7:0];
            default: b = {crc, 1'b1};
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sdspi_cfg.sv =====
// Configuration registers of the SD card SPI-mode sequencer.
// Holds the reply and data token wait limits; depends on sdspi_pkg.
`default_nettype none

module sdspi_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [0:0]                    i_cfg_index,
    input  wire logic [sdspi_pkg::LIMIT_W-1:0] i_cfg_data,
    output logic      [sdspi_pkg::LIMIT_W-1:0] o_reply_limit,
    output logic      [sdspi_pkg::LIMIT_W-1:0] o_token_limit
);
    import sdspi_pkg::*;

    logic [LIMIT_W-1:0] r_reply_limit;
    logic [LIMIT_W-1:0] r_token_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reply_limit <= REPLY_LIMIT_RST;
            r_token_limit <= TOKEN_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_REPLY_LIMIT: r_reply_limit <= i_cfg_data;
                CFG_TOKEN_LIMIT: r_token_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_reply_limit = r_reply_limit;
    assign o_token_limit = r_token_limit;

endmodule

`default_nettype wire

// ===== rtl/core/sdspi_seq.sv =====
// Command and data sequencer of the SD card SPI-mode block.
// Holds the protocol state and works out one result word per exchanged byte.
// Depends on sdspi_pkg.
`default_nettype none

module sdspi_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_fire,
    input  wire logic [1:0]                    i_action,
    input  wire logic [31:0]                   i_block_number,
    input  wire logic [7:0]                    i_rx_byte,
    input  wire logic [sdspi_pkg::LIMIT_W-1:0] i_reply_limit,
    input  wire logic [sdspi_pkg::LIMIT_W-1:0] i_token_limit,
    output sdspi_pkg::t_result                 o_result
);
    import sdspi_pkg::*;

    typedef enum logic [2:0] {
        P_IDLE,
        P_WAKE,
        P_FRAME,
        P_REPLY,
        P_EXTRA,
        P_TOKEN,
        P_DATA,
        P_CRC
    } t_phase;

    t_phase             r_phase, n_phase;
    t_cmd_step          r_step, n_step;
    logic [BC_W-1:0]    r_byte, n_byte;
    logic [RETRY_W-1:0] r_retry, n_retry;
    logic [LIMIT_W-1:0] r_wait, n_wait;
    logic [31:0]        r_addr, n_addr;
    logic [6:0]         r_reply, n_reply;

    t_result   res;
    logic      s_start;
    t_cmd_step s_step;
    logic      s_fin;
    logic [7:0] s_fin_st;
    logic      s_fin_to;
    logic      s_after;
    logic      reply_ok;
    logic [LIMIT_W-1:0] wait_inc;

    always_comb begin
        n_phase  = r_phase;
        n_step   = r_step;
        n_byte   = r_byte;
        n_retry  = r_retry;
        n_wait   = r_wait;
        n_addr   = r_addr;
        n_reply  = r_reply;
        res      = '0;
        res.tx_byte = FILL_BYTE;
        s_start  = 1'b0;
        s_step   = S_CMD17;
        s_fin    = 1'b0;
        s_fin_st = 8'h00;
        s_fin_to = 1'b0;
        s_after  = 1'b0;
        wait_inc = r_wait + LIMIT_W'(1);
        reply_ok = !i_rx_byte[7] && !(r_step == S_CMD0A && i_rx_byte == CMD0_BUSY);

        case (t_action'(i_action))
            ACT_INIT: begin
                n_phase = P_WAKE;
                n_byte  = BC_W'(1);
                n_retry = '0;
                n_wait  = '0;
            end
            ACT_READ: begin
                n_addr  = i_block_number;
                n_wait  = '0;
                s_start = 1'b1;
                s_step  = S_CMD17;
            end
            ACT_XFER: begin
                case (r_phase)
                    P_WAKE: begin
                        if (r_byte < BC_W'(WAKE_BYTES)) begin
                            n_byte = r_byte + BC_W'(1);
                        end else begin
                            s_start = 1'b1;
                            s_step  = S_CMD0A;
                        end
                    end
                    P_FRAME: begin
                        if (r_byte < BC_W'(6)) begin
                            res.tx_byte     = frame_byte(r_step, r_byte[2:0], r_addr);
                            res.card_select = 1'b1;
                            n_byte          = r_byte + BC_W'(1);
                        end else begin
                            n_phase         = P_REPLY;
                            n_wait          = '0;
                            res.card_select = 1'b1;
                        end
                    end
                    P_REPLY: begin
                        if (!reply_ok) begin
                            n_wait = wait_inc;
                            if (wait_inc >= i_reply_limit) begin
                                s_fin    = 1'b1;
                                s_fin_st = FILL_BYTE;
                                s_fin_to = 1'b1;
                            end else begin
                                res.card_select = 1'b1;
                            end
                        end else begin
                            n_reply = i_rx_byte[6:0];
                            if (r_step == S_CMD8 || r_step == S_CMD58) begin
                                n_phase         = P_EXTRA;
                                n_byte          = '0;
                                res.card_select = 1'b1;
                            end else begin
                                s_after = 1'b1;
                            end
                        end
                    end
                    P_EXTRA: begin
                        n_byte = r_byte + BC_W'(1);
                        if (n_byte < BC_W'(4)) begin
                            res.card_select = 1'b1;
                        end else begin
                            s_after = 1'b1;
                        end
                    end
                    P_TOKEN: begin
                        if (i_rx_byte == START_TOKEN) begin
                            n_phase         = P_DATA;
                            n_byte          = '0;
                            res.card_select = 1'b1;
                        end else if ((i_rx_byte & ERR_MASK) == 8'h00) begin
                            s_fin    = 1'b1;
                            s_fin_st = i_rx_byte;
                        end else begin
                            n_wait = wait_inc;
                            if (wait_inc >= i_token_limit) begin
                                s_fin    = 1'b1;
                                s_fin_st = FILL_BYTE;
                                s_fin_to = 1'b1;
                            end else begin
                                res.card_select = 1'b1;
                            end
                        end
                    end
                    P_DATA: begin
                        res.card_select = 1'b1;
                        res.data_byte   = i_rx_byte;
                        res.data_valid  = 1'b1;
                        if (r_byte >= BC_W'(BLOCK_BYTES - 1)) begin
                            n_phase = P_CRC;
                            n_byte  = '0;
                        end else begin
                            n_byte = r_byte + BC_W'(1);
                        end
                    end
                    P_CRC: begin
                        n_byte = r_byte + BC_W'(1);
                        if (n_byte < BC_W'(2)) begin
                            res.card_select = 1'b1;
                        end else begin
                            s_fin    = 1'b1;
                            s_fin_st = START_TOKEN;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        if (s_after) begin
            case (r_step)
                S_CMD0A: begin
                    s_start = 1'b1;
                    s_step  = S_CMD0B;
                end
                S_CMD0B: begin
                    s_start = 1'b1;
                    s_step  = S_CMD8;
                end
                S_CMD55: begin
                    s_start = 1'b1;
                    s_step  = S_ACMD41;
                end
                S_CMD58: begin
                    s_fin    = 1'b1;
                    s_fin_st = {1'b0, n_reply};
                end
                S_CMD8, S_ACMD41: begin
                    if (r_step == S_ACMD41) begin
                        n_retry = r_retry + RETRY_W'(1);
                    end
                    if (n_reply == R1_IDLE && n_retry < RETRY_W'(INIT_RETRIES)) begin
                        s_start = 1'b1;
                        s_step  = S_CMD55;
                    end else if (n_reply == R1_READY) begin
                        s_start = 1'b1;
                        s_step  = S_CMD58;
                    end else begin
                        s_fin    = 1'b1;
                        s_fin_st = {1'b0, n_reply};
                    end
                end
                default: begin
                    if (n_reply == R1_READY) begin
                        n_phase         = P_TOKEN;
                        n_wait          = '0;
                        res.card_select = 1'b1;
                    end else begin
                        s_fin    = 1'b1;
                        s_fin_st = {1'b0, n_reply};
                    end
                end
            endcase
        end

        if (s_start) begin
            n_step          = s_step;
            n_phase         = P_FRAME;
            n_byte          = BC_W'(1);
            res.tx_byte     = frame_byte(s_step, 3'd0, n_addr);
            res.card_select = 1'b1;
        end

        if (s_fin) begin
            n_phase         = P_IDLE;
            res.tx_byte     = FILL_BYTE;
            res.card_select = 1'b0;
            res.done_res    = 1'b1;
            res.status      = s_fin_st;
            res.timed_out   = s_fin_to;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_step  <= S_CMD0A;
            r_byte  <= '0;
            r_retry <= '0;
            r_wait  <= '0;
            r_addr  <= '0;
            r_reply <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_step  <= n_step;
            r_byte  <= n_byte;
            r_retry <= n_retry;
            r_wait  <= n_wait;
            r_addr  <= n_addr;
            r_reply <= n_reply;
        end
    end

    assign o_result = res;

endmodule

`default_nettype wire

// ===== rtl/core/sd_spi_init_and_block_read.sv =====
// SD card SPI-mode initialization and single block read sequencer, top level.
// Input word register, sequencer and result word register; depends on sdspi_pkg,
// sdspi_cfg and sdspi_seq.
//
// Each input word reports one event: start initialization, start a block read, or
// one byte exchange completed with the byte received. For each input word the block
// returns exactly one result word with the next byte to send, the chip select for it,
// any payload byte and, on the last byte of an operation, the completion report.
// A result word is registered after its input word has passed through the input
// register. A new word is accepted every cycle while the receiver does not stall; the
// rate is set by the single input and result registers around the sequencer logic. When
// the receiver stalls, the result register holds its word and one more input word may
// wait in the input register before o_in_stall rises. Reset clears both registers, the
// sequencer goes idle and the wait limits return to 8 fill bytes for a command reply
// and 4096 for the data start token. The user must write the limits through the
// configuration port while no operation is in progress; the block does not enforce it.
`default_nettype none

module sd_spi_init_and_block_read (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [0:0]                    i_cfg_index,
    input  wire logic [sdspi_pkg::LIMIT_W-1:0] i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_action,
    input  wire logic [31:0]                   i_block_number,
    input  wire logic [7:0]                    i_rx_byte,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [7:0]                         o_tx_byte,
    output logic                               o_card_select,
    output logic [7:0]                         o_data_byte,
    output logic                               o_data_valid,
    output logic                               o_done_res,
    output logic [7:0]                         o_status,
    output logic                               o_timed_out
);
    import sdspi_pkg::*;

    logic               r_in_valid;
    logic [1:0]         r_action;
    logic [31:0]        r_block_number;
    logic [7:0]         r_rx_byte;
    logic               r_out_valid;
    t_result            r_result;
    t_result            seq_result;
    logic               advance;
    logic               fire;
    logic               in_take;
    logic [LIMIT_W-1:0] reply_limit;
    logic [LIMIT_W-1:0] token_limit;

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    sdspi_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_reply_limit (reply_limit),
        .o_token_limit (token_limit)
    );

    sdspi_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_action       (r_action),
        .i_block_number (r_block_number),
        .i_rx_byte      (r_rx_byte),
        .i_reply_limit  (reply_limit),
        .i_token_limit  (token_limit),
        .o_result       (seq_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_action       <= i_action;
            r_block_number <= i_block_number;
            r_rx_byte      <= i_rx_byte;
        end
        if (fire) begin
            r_result <= seq_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_tx_byte     = r_result.tx_byte;
    assign o_card_select = r_result.card_select;
    assign o_data_byte   = r_result.data_byte;
    assign o_data_valid  = r_result.data_valid;
    assign o_done_res    = r_result.done_res;
    assign o_status      = r_result.status;
    assign o_timed_out   = r_result.timed_out;

endmodule

`default_nettype wire

// ===== verif/tb_sd_spi_init_and_block_read.sv =====
// Testbench for sd_spi_init_and_block_read: a card responder drives byte exchange words
// while a local model of the sequencer predicts every result word and checks it field by field.
// Depends on sdspi_pkg and the sd_spi_init_and_block_read RTL.
`default_nettype none

module tb_sd_spi_init_and_block_read;
    timeunit 1ns;
    timeprecision 1ps;

    import sdspi_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAKE,
        PH_FRAME,
        PH_REPLY,
        PH_EXTRA,
        PH_TOKEN,
        PH_DATA,
        PH_CRC
    } t_phase;

    typedef enum logic [1:0] {
        IDLE_SEND_LIGHT,
        IDLE_SEND_HEAVY,
        IDLE_NONE
    } t_idling;

    localparam logic [5:0]  CMD_GO_IDLE      = 6'd0;
    localparam logic [5:0]  CMD_IF_COND      = 6'd8;
    localparam logic [5:0]  CMD_READ_BLOCK   = 6'd17;
    localparam logic [5:0]  CMD_SEND_OP_COND = 6'd41;
    localparam logic [5:0]  CMD_APP          = 6'd55;
    localparam logic [5:0]  CMD_READ_OCR     = 6'd58;
    localparam logic [31:0] ARG_IF_COND      = 32'h0000_01AA;
    localparam logic [31:0] ARG_HCS          = 32'h4000_0000;
    localparam logic [6:0]  CRC_GO_IDLE      = 7'h4A;
    localparam logic [6:0]  CRC_IF_COND      = 7'h43;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_cfg_wr_en    = 1'b0;
    logic [0:0]          i_cfg_index    = CFG_REPLY_LIMIT;
    logic [LIMIT_W-1:0]  i_cfg_data     = '0;
    logic                i_in_valid     = 1'b0;
    logic [1:0]          i_action       = ACT_NONE;
    logic [31:0]         i_block_number = '0;
    logic [7:0]          i_rx_byte      = '0;
    logic                i_out_stall    = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [7:0]          o_tx_byte;
    logic                o_card_select;
    logic [7:0]          o_data_byte;
    logic                o_data_valid;
    logic                o_done_res;
    logic [7:0]          o_status;
    logic                o_timed_out;

    t_phase       ph          = PH_IDLE;
    t_cmd_step    step        = S_CMD0A;
    int           cnt         = 0;
    logic [10:0]  tries       = '0;
    logic [15:0]  waited      = '0;
    logic [31:0]  blk_addr    = '0;
    logic [7:0]   reply       = '0;
    logic [15:0]  reply_limit = REPLY_LIMIT_RST;
    logic [15:0]  token_limit = TOKEN_LIMIT_RST;

    t_result      due_words[$];
    int           bad_fields    = 0;
    int           words_seen    = 0;
    int           words_sent    = 0;
    int           send_idle_pct = 0;
    int           take_idle_pct = 0;

    sd_spi_init_and_block_read i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_block_number (i_block_number),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_tx_byte      (o_tx_byte),
        .o_card_select  (o_card_select),
        .o_data_byte    (o_data_byte),
        .o_data_valid   (o_data_valid),
        .o_done_res     (o_done_res),
        .o_status       (o_status),
        .o_timed_out    (o_timed_out)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [7:0] cmd_byte(t_cmd_step s, int k);
        logic [5:0]  idx;
        logic [31:0] arg;
        logic [6:0]  crc;
        idx = CMD_READ_BLOCK;
        arg = blk_addr;
        crc = '0;
        case (s)
            S_CMD0A, S_CMD0B: begin
                idx = CMD_GO_IDLE;
                arg = '0;
                crc = CRC_GO_IDLE;
            end
            S_CMD8: begin
                idx = CMD_IF_COND;
                arg = ARG_IF_COND;
                crc = CRC_IF_COND;
            end
            S_CMD55: begin
                idx = CMD_APP;
                arg = '0;
            end
            S_ACMD41: begin
                idx = CMD_SEND_OP_COND;
                arg = ARG_HCS;
            end
            S_CMD58: begin
                idx = CMD_READ_OCR;
                arg = '0;
            end
            default: ;
        endcase
        if (k == 0) return {2'b01, idx};
        if (k <= 4) return arg[8*(4-k) +: 8];
        return {crc, 1'b1};
    endfunction

    function automatic t_result word_out(logic [7:0] tx, logic cs);
        t_result r;
        r = '0;
        r.tx_byte = tx;
        r.card_select = cs;
        return r;
    endfunction

    function automatic t_result end_op(logic [7:0] st, logic to);
        t_result r;
        ph = PH_IDLE;
        r = word_out(FILL_BYTE, 1'b0);
        r.done_res = 1'b1;
        r.status = st;
        r.timed_out = to;
        return r;
    endfunction

    function automatic t_result begin_cmd(t_cmd_step s);
        step = s;
        ph = PH_FRAME;
        cnt = 1;
        return word_out(cmd_byte(s, 0), 1'b1);
    endfunction

    function automatic t_result after_reply();
        case (step)
            S_CMD0A: return begin_cmd(S_CMD0B);
            S_CMD0B: return begin_cmd(S_CMD8);
            S_CMD55: return begin_cmd(S_ACMD41);
            S_CMD58: return end_op(reply, 1'b0);
            S_CMD8, S_ACMD41: begin
                if (step == S_ACMD41) tries = tries + 1'b1;
                if (reply == {1'b0, R1_IDLE} && tries < INIT_RETRIES) return begin_cmd(S_CMD55);
                if (reply == {1'b0, R1_READY}) return begin_cmd(S_CMD58);
                return end_op(reply, 1'b0);
            end
            default: begin
                if (reply != {1'b0, R1_READY}) return end_op(reply, 1'b0);
                ph = PH_TOKEN;
                waited = '0;
                return word_out(FILL_BYTE, 1'b1);
            end
        endcase
    endfunction

    function automatic t_result sequencer_step(t_action act, logic [31:0] blk, logic [7:0] rx);
        t_result r;
        r = word_out(FILL_BYTE, 1'b0);
        case (act)
            ACT_INIT: begin
                ph = PH_WAKE;
                cnt = 1;
                tries = '0;
                waited = '0;
            end
            ACT_READ: begin
                blk_addr = blk;
                waited = '0;
                r = begin_cmd(S_CMD17);
            end
            ACT_XFER: begin
                case (ph)
                    PH_WAKE: begin
                        if (cnt < WAKE_BYTES) cnt++;
                        else r = begin_cmd(S_CMD0A);
                    end
                    PH_FRAME: begin
                        if (cnt < 6) begin
                            r = word_out(cmd_byte(step, cnt), 1'b1);
                            cnt++;
                        end else begin
                            ph = PH_REPLY;
                            waited = '0;
                            r = word_out(FILL_BYTE, 1'b1);
                        end
                    end
                    PH_REPLY: begin
                        if (rx[7] || (step == S_CMD0A && rx == CMD0_BUSY)) begin
                            waited = waited + 1'b1;
                            if (waited >= reply_limit) r = end_op(FILL_BYTE, 1'b1);
                            else r = word_out(FILL_BYTE, 1'b1);
                        end else begin
                            reply = rx;
                            if (step == S_CMD8 || step == S_CMD58) begin
                                ph = PH_EXTRA;
                                cnt = 0;
                                r = word_out(FILL_BYTE, 1'b1);
                            end else begin
                                r = after_reply();
                            end
                        end
                    end
                    PH_EXTRA: begin
                        cnt++;
                        if (cnt < 4) r = word_out(FILL_BYTE, 1'b1);
                        else r = after_reply();
                    end
                    PH_TOKEN: begin
                        if (rx == START_TOKEN) begin
                            ph = PH_DATA;
                            cnt = 0;
                            r = word_out(FILL_BYTE, 1'b1);
                        end else if ((rx & ERR_MASK) == '0) begin
                            r = end_op(rx, 1'b0);
                        end else begin
                            waited = waited + 1'b1;
                            if (waited >= token_limit) r = end_op(FILL_BYTE, 1'b1);
                            else r = word_out(FILL_BYTE, 1'b1);
                        end
                    end
                    PH_DATA: begin
                        r = word_out(FILL_BYTE, 1'b1);
                        r.data_byte = rx;
                        r.data_valid = 1'b1;
                        if (cnt >= BLOCK_BYTES - 1) begin
                            ph = PH_CRC;
                            cnt = 0;
                        end else begin
                            cnt++;
                        end
                    end
                    PH_CRC: begin
                        cnt++;
                        if (cnt < 2) r = word_out(FILL_BYTE, 1'b1);
                        else r = end_op(START_TOKEN, 1'b0);
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] result word %0d: %s", $realtime, words_seen, msg);
        bad_fields++;
    endtask

    task automatic check_field(string field, logic [7:0] got, logic [7:0] want);
        if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
    endtask

    always @(posedge i_clk) begin : check_words
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            words_seen++;
            if (due_words.size() == 0) begin
                report_mismatch("arrived with no word expected");
            end else begin
                want = due_words.pop_front();
                check_field("tx_byte", o_tx_byte, want.tx_byte);
                check_field("card_select", {7'b0, o_card_select}, {7'b0, want.card_select});
                check_field("data_byte", o_data_byte, want.data_byte);
                check_field("data_valid", {7'b0, o_data_valid}, {7'b0, want.data_valid});
                check_field("done_res", {7'b0, o_done_res}, {7'b0, want.done_res});
                check_field("status", o_status, want.status);
                check_field("timed_out", {7'b0, o_timed_out}, {7'b0, want.timed_out});
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < take_idle_pct);
    end

    task automatic set_idling(t_idling mode);
        case (mode)
            IDLE_SEND_LIGHT: begin
                send_idle_pct = 27;
                take_idle_pct = 55;
            end
            IDLE_SEND_HEAVY: begin
                send_idle_pct = 55;
                take_idle_pct = 27;
            end
            default: begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end
        endcase
    endtask

    task automatic send_word(t_action act, logic [31:0] blk, logic [7:0] rx);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_block_number <= blk;
        i_rx_byte <= rx;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        due_words.push_back(sequencer_step(act, blk, rx));
        if (act != ACT_NONE) words_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_limits(logic [15:0] reply_fill, logic [15:0] token_fill);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_REPLY_LIMIT;
        i_cfg_data <= reply_fill;
        @(posedge i_clk);
        i_cfg_index <= CFG_TOKEN_LIMIT;
        i_cfg_data <= token_fill;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        reply_limit = reply_fill;
        token_limit = token_fill;
    endtask

    // Plays the card side of one operation, answering from the predicted sequencer phase.
    task automatic card_session(t_action start, int budget, int busy, int fault_pct, bit clean);
        int         n;
        int         busy_left;
        logic [7:0] rx;
        t_action    act;
        send_word(start, $urandom(), 8'($urandom()));
        n = 0;
        busy_left = busy;
        while (ph != PH_IDLE && n < budget) begin
            rx = 8'($urandom());
            act = ACT_XFER;
            if (ph == PH_REPLY) begin
                if ($urandom_range(99) < fault_pct) begin
                    if (step == S_CMD0A && $urandom_range(1) == 0) rx = CMD0_BUSY;
                    else rx[7] = 1'b1;
                end else begin
                    rx[7] = 1'b0;
                    if (step == S_CMD8 && (clean || $urandom_range(9) != 0)) rx = {1'b0, R1_IDLE};
                    if (step == S_CMD17 && (clean || $urandom_range(9) != 0)) rx = {1'b0, R1_READY};
                    if (step == S_ACMD41 && (clean || $urandom_range(19) != 0)) begin
                        rx = (busy_left > 0) ? {1'b0, R1_IDLE} : {1'b0, R1_READY};
                        if (busy_left > 0) busy_left--;
                    end
                end
            end else if (ph == PH_TOKEN) begin
                if ($urandom_range(99) < fault_pct) begin
                    rx = rx | 8'h20;
                    if (rx == START_TOKEN) rx = FILL_BYTE;
                end else if (clean || $urandom_range(9) != 0) begin
                    rx = START_TOKEN;
                end else begin
                    rx = rx & ~ERR_MASK;
                end
            end else if (!clean && $urandom_range(49) == 0) begin
                act = ACT_NONE;
            end
            send_word(act, $urandom(), rx);
            n++;
        end
    endtask

    task automatic test_idle_words();
        send_word(ACT_NONE, 32'hFFFF_FFFF, 8'hFF);
        send_word(ACT_XFER, 32'h0000_0000, 8'h00);
        send_word(ACT_XFER, 32'hFFFF_FFFF, 8'hFF);
    endtask

    task automatic test_read_faults();
        send_word(ACT_READ, 32'hFFFF_FFFF, 8'h00);
        send_word(ACT_NONE, 32'h0000_0000, 8'h00);
        repeat (3) begin
            send_word(ACT_XFER, 32'h0000_0000, 8'h00);
            send_word(ACT_XFER, 32'hFFFF_FFFF, 8'hFF);
        end
        send_word(ACT_XFER, 32'h0, 8'hFF);
        send_word(ACT_XFER, 32'h0, 8'h80);
        send_word(ACT_XFER, 32'h0, {1'b0, R1_READY});
        send_word(ACT_XFER, 32'h0, 8'hE0);
        send_word(ACT_XFER, 32'h0, 8'h08);
        send_word(ACT_READ, 32'h0000_0000, 8'hFF);
        repeat (6) send_word(ACT_XFER, 32'h0, 8'hFF);
        send_word(ACT_XFER, 32'h0, 8'h7F);
    endtask

    task automatic test_random_traffic(int items);
        int first;
        int pick;
        int left;
        int budget;
        first = words_sent;
        while (words_sent - first < items) begin
            left = items - (words_sent - first);
            pick = $urandom_range(99);
            if (pick < 40) begin
                budget = $urandom_range(20, 150);
                if (budget > left) budget = left;
                card_session(ACT_INIT, budget, $urandom_range(0, 3), 15, 1'b0);
            end else if (pick < 85) begin
                budget = $urandom_range(10, 80);
                if (budget > left) budget = left;
                card_session(ACT_READ, budget, 0, 20, 1'b0);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_word(t_action'($urandom_range(3)), $urandom(), 8'($urandom()));
                end
            end
            if ($urandom_range(7) == 0) drain();
        end
    endtask

    task automatic test_init_and_full_read();
        set_limits(16'hFFFF, 16'hFFFF);
        card_session(ACT_INIT, 100000, 2, 10, 1'b1);
        card_session(ACT_READ, 100000, 0, 10, 1'b1);
    endtask

    initial begin
        #12_000_000;
        $display("tb_sd_spi_init_and_block_read: done, errors");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_idling(IDLE_SEND_LIGHT);
        test_idle_words();
        test_read_faults();
        set_limits(16'd1, 16'd1);
        test_random_traffic(20);
        set_idling(IDLE_SEND_HEAVY);
        test_init_and_full_read();
        set_limits(16'd2, 16'd3);
        test_random_traffic(15);
        set_idling(IDLE_NONE);
        set_limits(16'd5, 16'd40);
        test_random_traffic(20);
        drain();
        repeat (8) @(posedge i_clk);
        if (bad_fields == 0 && due_words.size() == 0) begin
            $display("tb_sd_spi_init_and_block_read: done, clean");
        end else begin
            $display("tb_sd_spi_init_and_block_read: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
